// File: hdl/med_pkg.sv
package med_pkg;

  localparam int FLOOR_W = 4;
  localparam int HEAD_W = 2;
  localparam int IDX_W = 2;

  localparam int NUM_CARS_DEF = 3;
  localparam int NUM_FLOORS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = 4'd9;

  localparam logic FUNC_CALL = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [HEAD_W-1:0] HEAD_UP = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_IDLE = 2'd2;

  // one queued command between front and back
  typedef struct packed {
    logic               tick;
    logic               call_ok;
    logic [FLOOR_W-1:0] floor;
    logic               dir;
  } cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_REPORT
  } back_state_t;

endpackage

// File: hdl/med_in_if.sv
interface med_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [med_pkg::FLOOR_W-1:0] call_floor;
  logic                        call_dir;

  modport source (output valid, output func, output call_floor, output call_dir,
                  input ready);
  modport sink (input valid, input func, input call_floor, input call_dir,
                output ready);
endinterface

// File: hdl/med_out_if.sv
interface med_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [med_pkg::IDX_W-1:0]   car_index;
  logic                        assigned_valid;
  logic [med_pkg::FLOOR_W-1:0] car_position;
  logic [med_pkg::HEAD_W-1:0]  car_heading;
  logic                        last;

  modport source (output valid, output result_kind, output car_index,
                  output assigned_valid, output car_position, output car_heading,
                  output last, input ready);
  modport sink (input valid, input result_kind, input car_index,
                input assigned_valid, input car_position, input car_heading,
                input last, output ready);
endinterface

// File: hdl/med_front.sv
module med_front #(
  parameter int NUM_FLOORS = med_pkg::NUM_FLOORS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [med_pkg::FLOOR_W-1:0] cfg_wdata,
  med_in_if.sink                      req,
  output logic                        push,
  output med_pkg::cmd_t               push_data,
  input  logic                        full
);

  logic [med_pkg::FLOOR_W-1:0] top_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_floor <= med_pkg::TOP_FLOOR_RESET;
    end else if (cfg_we) begin
      top_floor <= cfg_wdata;
    end
  end

  assign req.ready = !full;
  assign push = req.valid && !full;

  always_comb begin
    push_data.tick = (req.func == med_pkg::FUNC_TICK);
    push_data.call_ok = (req.call_floor <= top_floor) && (32'(req.call_floor) < NUM_FLOORS);
    push_data.floor = req.call_floor;
    push_data.dir = req.call_dir;
  end

endmodule

// File: hdl/med_queue.sv
module med_queue #(
  parameter int DEPTH = med_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  med_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output med_pkg::cmd_t pop_data,
  output logic          pop_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  med_pkg::cmd_t    slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/med_back.sv
module med_back #(
  parameter int NUM_CARS   = med_pkg::NUM_CARS_DEF,
  parameter int NUM_FLOORS = med_pkg::NUM_FLOORS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  med_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          pop,
  med_out_if.source     rsp
);

  localparam int FW = (NUM_FLOORS > 16) ? $clog2(NUM_FLOORS) : med_pkg::FLOOR_W;
  localparam int CIW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int NF = NUM_FLOORS;
  localparam int HW = med_pkg::HEAD_W;

  function automatic logic [HW-1:0] heading(input logic [FW-1:0] f,
                                            input logic [NF-1:0] m,
                                            input logic [HW-1:0] d);
    logic below;
    logic above;
    logic [HW-1:0] h;
    below = 1'b0;
    above = 1'b0;
    for (int i = 0; i < NF; i++) begin
      if (m[i] && (FW'(i) < f)) below = 1'b1;
      if (m[i] && (FW'(i) > f)) above = 1'b1;
    end
    if (m == '0) begin
      h = med_pkg::HEAD_IDLE;
    end else if (above && !below) begin
      h = med_pkg::HEAD_UP;
    end else if (below && !above) begin
      h = med_pkg::HEAD_DOWN;
    end else if (above && below) begin
      // both sides pending: keep heading, idle car starts upward
      h = (d == med_pkg::HEAD_UP || d == med_pkg::HEAD_DOWN) ? d : med_pkg::HEAD_UP;
    end else begin
      h = med_pkg::HEAD_IDLE;
    end
    return h;
  endfunction

  logic [FW-1:0] car_floor [NUM_CARS];
  logic [HW-1:0] car_dir   [NUM_CARS];
  logic [NF-1:0] stop_mask [NUM_CARS];

  med_pkg::back_state_t state;
  med_pkg::back_state_t state_next;
  logic [CIW-1:0]       rep_idx;
  logic                 rep_last;

  logic                        out_valid;
  logic                        out_kind;
  logic [med_pkg::IDX_W-1:0]   out_index;
  logic                        out_assigned;
  logic [med_pkg::FLOOR_W-1:0] out_position;
  logic [HW-1:0]               out_heading;
  logic                        out_last;

  logic out_free;
  logic load_call;
  logic load_tick;
  logic load_rep;

  // tick: next position, mask and heading of every car
  logic [FW-1:0] mv_floor [NUM_CARS];
  logic [HW-1:0] mv_dir   [NUM_CARS];
  logic [NF-1:0] mv_mask  [NUM_CARS];

  always_comb begin
    for (int c = 0; c < NUM_CARS; c++) begin
      mv_floor[c] = car_floor[c];
      mv_mask[c] = stop_mask[c];
      mv_dir[c] = med_pkg::HEAD_IDLE;
      if (stop_mask[c] != '0) begin
        if (car_dir[c] == med_pkg::HEAD_UP && car_floor[c] != FW'(NF - 1)) begin
          mv_floor[c] = car_floor[c] + 1'b1;
        end else if (car_dir[c] == med_pkg::HEAD_DOWN && car_floor[c] != '0) begin
          mv_floor[c] = car_floor[c] - 1'b1;
        end
        mv_mask[c] = stop_mask[c] & ~(NF'(1) << mv_floor[c]);
        mv_dir[c] = heading(mv_floor[c], mv_mask[c], car_dir[c]);
      end
    end
  end

  // call: nearest qualifying car, lowest index on a tie
  logic [FW-1:0]  call_floor;
  logic [FW-1:0]  gap      [NUM_CARS];
  logic           elig     [NUM_CARS];
  logic [NF-1:0]  cand_mask[NUM_CARS];
  logic [HW-1:0]  cand_dir [NUM_CARS];
  logic           found;
  logic [CIW-1:0] best_idx;
  logic [FW-1:0]  best_gap;
  logic [FW-1:0]  best_floor;
  logic [HW-1:0]  best_dir;
  logic [NF-1:0]  best_mask;

  assign call_floor = FW'(cmd.floor);

  always_comb begin
    for (int c = 0; c < NUM_CARS; c++) begin
      gap[c] = (car_floor[c] > call_floor) ? car_floor[c] - call_floor
                                           : call_floor - car_floor[c];
      elig[c] = cmd.call_ok && ((car_dir[c] == {1'b0, cmd.dir}) ||
                                (car_dir[c] == med_pkg::HEAD_IDLE));
      cand_mask[c] = (car_floor[c] != call_floor) ?
                     (stop_mask[c] | (NF'(1) << call_floor)) : stop_mask[c];
      cand_dir[c] = heading(car_floor[c], cand_mask[c], car_dir[c]);
    end
  end

  always_comb begin
    found = 1'b0;
    best_idx = '0;
    best_gap = '0;
    best_floor = '0;
    best_dir = '0;
    best_mask = '0;
    for (int c = 0; c < NUM_CARS; c++) begin
      if (elig[c] && (!found || gap[c] < best_gap)) begin
        found = 1'b1;
        best_idx = CIW'(c);
        best_gap = gap[c];
        best_floor = car_floor[c];
        best_dir = cand_dir[c];
        best_mask = cand_mask[c];
      end
    end
  end

  assign out_free = !out_valid || rsp.ready;
  assign rep_last = (rep_idx == CIW'(NUM_CARS - 1));

  always_comb begin
    state_next = state;
    case (state)
      med_pkg::BK_RUN: begin
        if (cmd_valid && out_free && cmd.tick && NUM_CARS > 1) begin
          state_next = med_pkg::BK_REPORT;
        end
      end
      med_pkg::BK_REPORT: begin
        if (out_free && rep_last) begin
          state_next = med_pkg::BK_RUN;
        end
      end
      default: state_next = med_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    load_call = 1'b0;
    load_tick = 1'b0;
    load_rep = 1'b0;
    case (state)
      med_pkg::BK_RUN: begin
        pop = cmd_valid && out_free;
        load_call = pop && !cmd.tick;
        load_tick = pop && cmd.tick;
      end
      med_pkg::BK_REPORT: begin
        load_rep = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= med_pkg::BK_RUN;
      rep_idx <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CARS; c++) begin
        car_floor[c] <= '0;
        car_dir[c] <= med_pkg::HEAD_IDLE;
        stop_mask[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (load_call || load_tick || load_rep) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (load_tick) begin
        rep_idx <= CIW'(1);
        for (int c = 0; c < NUM_CARS; c++) begin
          car_floor[c] <= mv_floor[c];
          car_dir[c] <= mv_dir[c];
          stop_mask[c] <= mv_mask[c];
        end
      end
      if (load_call && found) begin
        for (int c = 0; c < NUM_CARS; c++) begin
          if (CIW'(c) == best_idx) begin
            car_dir[c] <= best_dir;
            stop_mask[c] <= best_mask;
          end
        end
      end
      if (load_rep) begin
        rep_idx <= rep_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_call) begin
      out_kind <= med_pkg::KIND_CALL;
      out_last <= 1'b1;
      out_assigned <= found;
      out_index <= found ? med_pkg::IDX_W'(best_idx) : '0;
      out_position <= found ? med_pkg::FLOOR_W'(best_floor) : '0;
      out_heading <= found ? best_dir : '0;
    end else if (load_tick) begin
      out_kind <= med_pkg::KIND_STATUS;
      out_last <= (NUM_CARS == 1);
      out_assigned <= 1'b0;
      out_index <= '0;
      out_position <= med_pkg::FLOOR_W'(mv_floor[0]);
      out_heading <= mv_dir[0];
    end else if (load_rep) begin
      out_kind <= med_pkg::KIND_STATUS;
      out_last <= rep_last;
      out_assigned <= 1'b0;
      out_index <= med_pkg::IDX_W'(rep_idx);
      out_position <= med_pkg::FLOOR_W'(car_floor[rep_idx]);
      out_heading <= car_dir[rep_idx];
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.car_index = out_index;
  assign rsp.assigned_valid = out_assigned;
  assign rsp.car_position = out_position;
  assign rsp.car_heading = out_heading;
  assign rsp.last = out_last;

endmodule

// File: hdl/multi_car_elevator_dispatcher.sv
// Nearest-car elevator dispatcher. Requests enter through a front stage that
// checks the call floor against top_floor and lands them in a two-entry queue;
// the back end owns the car floors, headings and stop masks. A hall call at the
// queue head leaves once the output register is free, its one beat valid from
// that edge. A tick moves all cars at once and gives NUM_CARS status beats, as
// the single output register holds one beat at a time; the next item leaves
// the queue after the last status beat. While the output does not stall, calls
// stream and status beats come one per cycle. The front takes input while the
// queue has room, also during reports and stalls. The user must write top_floor
// via cfg_we/cfg_wdata only while the block is idle, which it does not enforce.
module multi_car_elevator_dispatcher #(
  parameter int NUM_CARS    = med_pkg::NUM_CARS_DEF,
  parameter int NUM_FLOORS  = med_pkg::NUM_FLOORS_DEF,
  parameter int QUEUE_DEPTH = med_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [med_pkg::FLOOR_W-1:0] cfg_wdata,
  med_in_if.sink                      req,
  med_out_if.source                   rsp
);

  logic          push;
  med_pkg::cmd_t push_data;
  logic          full;
  logic          pop;
  med_pkg::cmd_t pop_data;
  logic          pop_valid;

  med_front #(
    .NUM_FLOORS(NUM_FLOORS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req),
    .push(push),
    .push_data(push_data),
    .full(full)
  );

  med_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .pop_data(pop_data),
    .pop_valid(pop_valid)
  );

  med_back #(
    .NUM_CARS(NUM_CARS),
    .NUM_FLOORS(NUM_FLOORS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd(pop_data),
    .cmd_valid(pop_valid),
    .pop(pop),
    .rsp(rsp)
  );

endmodule

// File: dv/multi_car_elevator_dispatcher_tb.sv
module multi_car_elevator_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import med_pkg::*;

  localparam int CARS = NUM_CARS_DEF;
  localparam int FLOORS = NUM_FLOORS_DEF;
  localparam int PHASE_ITEMS = 70;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic               func;
    logic [FLOOR_W-1:0] floor;
    logic               dir;
  } hall_req_t;

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   idx;
    logic               assigned;
    logic [FLOOR_W-1:0] pos;
    logic [HEAD_W-1:0]  head;
    logic               last;
  } car_report_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [FLOOR_W-1:0] cfg_wdata;

  med_in_if req_if ();
  med_out_if rsp_if ();

  multi_car_elevator_dispatcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // car state as the dispatcher should hold it
  logic [FLOOR_W-1:0] car_floor [CARS];
  logic [HEAD_W-1:0]  car_head [CARS];
  logic [FLOORS-1:0]  car_stops [CARS];
  logic [FLOOR_W-1:0] top_floor_model;

  hall_req_t   request_feed [$];
  car_report_t expected_reports [$];
  hall_req_t   in_flight;

  bit quiet_tail;
  int send_gap;
  int stall_left;
  int idle_cycles;
  int mismatches;
  int calls_seen, ticks_seen, calls_assigned, calls_refused, status_beats, settings_used;

  function automatic logic [HEAD_W-1:0] next_heading(logic [FLOOR_W-1:0] f,
                                                     logic [FLOORS-1:0] m,
                                                     logic [HEAD_W-1:0] h);
    logic [31:0] below_mask;
    logic [31:0] above_mask;
    logic [FLOORS-1:0] below;
    logic [FLOORS-1:0] above;
    below_mask = (32'd1 << f) - 32'd1;
    above_mask = ~((32'd2 << f) - 32'd1);
    below = m & below_mask[FLOORS-1:0];
    above = m & above_mask[FLOORS-1:0];
    if (m == '0) return HEAD_IDLE;
    if (above != '0 && below == '0) return HEAD_UP;
    if (below != '0 && above == '0) return HEAD_DOWN;
    if (above != '0 && below != '0) begin
      if (h != HEAD_UP && h != HEAD_DOWN) return HEAD_UP;
      return h;
    end
    return HEAD_IDLE;
  endfunction

  task automatic dispatch_call(hall_req_t r);
    int best;
    int bestd;
    int d;
    car_report_t rep;
    best = -1;
    bestd = 0;
    calls_seen++;
    if (r.floor <= top_floor_model) begin
      for (int c = 0; c < CARS; c++) begin
        d = (car_floor[c] > r.floor) ? car_floor[c] - r.floor : r.floor - car_floor[c];
        if ((car_head[c] == {1'b0, r.dir} || car_head[c] == HEAD_IDLE) &&
            (best < 0 || d < bestd)) begin
          best = c;
          bestd = d;
        end
      end
    end
    rep = '0;
    rep.kind = KIND_CALL;
    rep.last = 1'b1;
    if (best >= 0) begin
      if (car_floor[best] != r.floor) car_stops[best][r.floor] = 1'b1;
      car_head[best] = next_heading(car_floor[best], car_stops[best], car_head[best]);
      rep.idx = best[IDX_W-1:0];
      rep.assigned = 1'b1;
      rep.pos = car_floor[best];
      rep.head = car_head[best];
      calls_assigned++;
    end else begin
      calls_refused++;
    end
    expected_reports.push_back(rep);
  endtask

  task automatic advance_cars();
    car_report_t rep;
    ticks_seen++;
    for (int c = 0; c < CARS; c++) begin
      if (car_stops[c] == '0) begin
        car_head[c] = HEAD_IDLE;
      end else begin
        if (car_head[c] == HEAD_UP && car_floor[c] < FLOORS - 1) car_floor[c]++;
        else if (car_head[c] == HEAD_DOWN && car_floor[c] > 0) car_floor[c]--;
        car_stops[c][car_floor[c]] = 1'b0;
        car_head[c] = next_heading(car_floor[c], car_stops[c], car_head[c]);
      end
    end
    for (int c = 0; c < CARS; c++) begin
      rep.kind = KIND_STATUS;
      rep.idx = c[IDX_W-1:0];
      rep.assigned = 1'b0;
      rep.pos = car_floor[c];
      rep.head = car_head[c];
      rep.last = (c == CARS - 1);
      expected_reports.push_back(rep);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_beat();
    car_report_t got;
    car_report_t want;
    got.kind = rsp_if.result_kind;
    got.idx = rsp_if.car_index;
    got.assigned = rsp_if.assigned_valid;
    got.pos = rsp_if.car_position;
    got.head = rsp_if.car_heading;
    got.last = rsp_if.last;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %p", got));
    end else begin
      want = expected_reports.pop_front();
      if (got.kind == KIND_STATUS) status_beats++;
      if (got.kind != want.kind)
        report_mismatch($sformatf("result_kind %0d want %0d", got.kind, want.kind));
      if (got.idx != want.idx)
        report_mismatch($sformatf("car_index %0d want %0d", got.idx, want.idx));
      if (got.assigned != want.assigned)
        report_mismatch($sformatf("assigned_valid %0d want %0d", got.assigned, want.assigned));
      if (got.pos != want.pos)
        report_mismatch($sformatf("car_position %0d want %0d", got.pos, want.pos));
      if (got.head != want.head)
        report_mismatch($sformatf("car_heading %0d want %0d", got.head, want.head));
      if (got.last != want.last)
        report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
    end
  endtask

  task automatic push_call(int floor, logic dir);
    hall_req_t r;
    r.func = FUNC_CALL;
    r.floor = floor[FLOOR_W-1:0];
    r.dir = dir;
    request_feed.push_back(r);
  endtask

  task automatic push_tick();
    hall_req_t r;
    r.func = FUNC_TICK;
    r.floor = 4'($urandom_range(0, FLOORS - 1));
    r.dir = 1'($urandom_range(0, 1));
    request_feed.push_back(r);
  endtask

  task automatic write_top_floor(logic [FLOOR_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    top_floor_model = v;
    settings_used++;
  endtask

  // sampled away from the rising edge so driver updates have settled
  task automatic drain();
    @(negedge clk);
    while (request_feed.size() != 0 || req_if.valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (in_flight.func == FUNC_TICK) advance_cars();
        else dispatch_call(in_flight);
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 9);
          req_if.valid <= 1'b0;
        end else if (request_feed.size() != 0) begin
          in_flight = request_feed.pop_front();
          req_if.func <= in_flight.func;
          req_if.call_floor <= in_flight.floor;
          req_if.call_dir <= in_flight.dir;
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_beat();
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 9);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no beat for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    logic [FLOOR_W-1:0] settings [5];
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_CALL;
    req_if.call_floor = '0;
    req_if.call_dir = 1'b0;
    rsp_if.ready = 1'b0;
    quiet_tail = 1'b0;
    idle_cycles = 0;
    mismatches = 0;
    top_floor_model = TOP_FLOOR_RESET;
    for (int c = 0; c < CARS; c++) begin
      car_floor[c] = '0;
      car_head[c] = HEAD_IDLE;
      car_stops[c] = '0;
    end
    settings = '{4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd9, 4'd15};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset value of top_floor
    settings_used = 1;
    push_call(0, 1'b0);    // own floor, served at once
    push_call(15, 1'b1);   // above top_floor
    push_call(10, 1'b0);
    push_call(9, 1'b1);    // car 0 heads up
    push_call(4, 1'b1);    // car 0 not eligible, car 1 takes it
    push_call(3, 1'b1);    // car 2 takes it
    push_call(2, 1'b1);    // no eligible car
    push_tick();
    push_call(0, 1'b0);    // tie on distance, stops above and below car 0
    repeat (14) push_tick();
    drain();

    foreach (settings[p]) begin
      if (p == 4) quiet_tail = 1'b1;
      write_top_floor(settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 35) begin
          push_tick();
        end else begin
          r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, FLOORS - 1)
                                          : $urandom_range(0, settings[p]);
          push_call(r, 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    $display("covered %0d hall calls (%0d assigned, %0d refused) and %0d ticks",
             calls_seen, calls_assigned, calls_refused, ticks_seen);
    $display("checked %0d status beats over %0d top_floor settings, %0d mismatches",
             status_beats, settings_used, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/med_pkg.sv
hdl/med_in_if.sv
hdl/med_out_if.sv
hdl/med_front.sv
hdl/med_queue.sv
hdl/med_back.sv
hdl/multi_car_elevator_dispatcher.sv
dv/multi_car_elevator_dispatcher_tb.sv
